// ===== rtl/unix_time_to_calendar_unit_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef UNIX_TIME_TO_CALENDAR_UNIT_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define UT2CAL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ut2cal: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define UT2CAL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ut2cal: next-cycle check failed");

`endif

// ===== rtl/ut2cal_pkg.sv =====
package ut2cal_pkg;

   // field types
   typedef logic [31:0] stamp_type;
   typedef logic [16:0] zone_type;
   typedef logic [11:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  day_type;
   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minute_type;
   typedef logic [5:0]  second_type;
   typedef logic [15:0] days_type;
   typedef logic [16:0] sod_type;

   localparam int ZONE_W     = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ZONE_RESET = 28800;

   // register index codes
   typedef enum logic [0:0] {
      REG_ZONE_OFFSET = 1'b0
   } csr_index_type;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam int          EPOCH_YEAR    = 1970;

   // reciprocals: t/86400 = (t>>7)/675, d/365, sod/3600, rem/60
   localparam int          RECIP_DAY_SH  = 35;
   localparam logic [25:0] RECIP_DAY     = 26'((64'd1 << RECIP_DAY_SH) / 64'd675);
   localparam int          RECIP_YEAR_SH = 25;
   localparam logic [16:0] RECIP_YEAR    = 17'(((64'd1 << RECIP_YEAR_SH) + 64'd364) / 64'd365);
   localparam int          RECIP_HOUR_SH = 28;
   localparam logic [16:0] RECIP_HOUR    = 17'(((64'd1 << RECIP_HOUR_SH) + 64'd3599) / 64'd3600);
   localparam int          RECIP_MIN_SH  = 18;
   localparam logic [12:0] RECIP_MIN     = 13'(((64'd1 << RECIP_MIN_SH) + 64'd59) / 64'd60);

   // years 1970..2107 covered by the year tables
   localparam int YEAR_TAB_N  = 138;
   localparam int EPOCH_MOD4   = EPOCH_YEAR % 4;
   localparam int EPOCH_MOD100 = EPOCH_YEAR % 100;
   localparam int EPOCH_MOD400 = EPOCH_YEAR % 400;

   typedef logic [YEAR_TAB_N-1:0] leap_tab_type;
   typedef logic [15:0] year_start_tab_type [0:YEAR_TAB_N-1];

   // bit i set when year EPOCH_YEAR+i is a leap year
   function automatic leap_tab_type build_leap_tab();
      leap_tab_type tab;
      int r4;
      int r100;
      int r400;
      tab  = '0;
      r4   = EPOCH_MOD4;
      r100 = EPOCH_MOD100;
      r400 = EPOCH_MOD400;
      for (int i = 0; i < YEAR_TAB_N; i++) begin
         tab[i] = (r4 == 0) && ((r100 != 0) || (r400 == 0));
         r4   = (r4 == 3) ? 0 : r4 + 1;
         r100 = (r100 == 99) ? 0 : r100 + 1;
         r400 = (r400 == 399) ? 0 : r400 + 1;
      end
      return tab;
   endfunction

   localparam leap_tab_type LEAP_YEARS = build_leap_tab();

   // day number of January 1 of year EPOCH_YEAR+i
   function automatic year_start_tab_type build_year_start();
      year_start_tab_type tab;
      int acc;
      acc = 0;
      for (int i = 0; i < YEAR_TAB_N; i++) begin
         tab[i] = 16'(acc);
         acc    = acc + (LEAP_YEARS[i] ? 366 : 365);
      end
      return tab;
   endfunction

   localparam year_start_tab_type YEAR_START = build_year_start();

   // first day of each month in a common year
   typedef logic [8:0] month_start_tab_type [0:11];
   localparam month_start_tab_type MONTH_START = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // day count and second of day after the first split
   typedef struct packed {
      days_type days;
      sod_type  sod;
   } day_split_type;

   typedef struct packed {
      year_type  year;
      month_type month;
      day_type   day;
   } date_type;

   typedef struct packed {
      hour_type   hour;
      minute_type minute;
      second_type second;
   } clock_type;

endpackage

// ===== rtl/ut2cal_req_if.sv =====
interface ut2cal_req_if;
   import ut2cal_pkg::*;

   logic      valid;
   logic      ready;
   stamp_type timestamp;

   modport source (output valid, output timestamp, input ready);
   modport sink   (input valid, input timestamp, output ready);
endinterface

// ===== rtl/ut2cal_rsp_if.sv =====
interface ut2cal_rsp_if;
   import ut2cal_pkg::*;

   logic       valid;
   logic       ready;
   year_type   year;
   month_type  month;
   day_type    day;
   hour_type   hour;
   minute_type minute;
   second_type second;

   modport source (output valid, output year, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface

// ===== rtl/unix_time_to_calendar_unit.sv =====
// An accepted timestamp runs through the day split, the date and clock stages and the output register.
// Throughput: one item per cycle; a stalled result holds the whole 9-stage pipeline.
// The stages hold the chained constant-reciprocal multiplies (days, years, hours, minutes).
// Reset (synchronous, active high) empties the pipeline and sets the zone offset to +8 h.
module unix_time_to_calendar_unit (
   input  logic                              clock,
   input  logic                              reset,
   ut2cal_req_if.sink                        req_bus,
   ut2cal_rsp_if.source                      rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ut2cal_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ut2cal_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ut2cal_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);
   import ut2cal_pkg::*;

   localparam int STAGES = 9;

   logic              en;
   logic [STAGES-1:0] vld_in, vld_ff;
   zone_type          zone_in, zone_ff;
   csr_index_type     csr_idx;
   logic              csr_wr;
   day_split_type     split;
   date_type          date;
   clock_type         hms;
   date_type          date_out_in, date_out_ff;
   clock_type         hms_out_in, hms_out_ff;

   // whole pipeline moves unless the result is waiting
   assign en            = !vld_ff[STAGES-1] || rsp_bus.ready;
   assign req_bus.ready = en;

   // config port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_idx == REG_ZONE_OFFSET);
   assign zone_in    = csr_wr ? csr_pwdata[ZONE_W-1:0] : zone_ff;
   assign csr_prdata = (csr_idx == REG_ZONE_OFFSET) ?
                       {{(CSR_DATA_W-ZONE_W){1'b0}}, zone_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_W'(ZONE_RESET);
      end else begin
         zone_ff <= zone_in;
      end
   end

   // valid bits travel with the data
   assign vld_in = en ? {vld_ff[STAGES-2:0], req_bus.valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   ut2cal_day_split u_day_split (
      .clock (clock),
      .en    (en),
      .stamp (req_bus.timestamp),
      .zone  (zone_ff),
      .split (split)
   );

   ut2cal_date u_date (
      .clock (clock),
      .en    (en),
      .days  (split.days),
      .date  (date)
   );

   ut2cal_clock u_clock (
      .clock (clock),
      .en    (en),
      .sod   (split.sod),
      .hms   (hms)
   );

   // output register, last stage
   assign date_out_in = en ? date : date_out_ff;
   assign hms_out_in  = en ? hms : hms_out_ff;

   always_ff @(posedge clock) begin
      date_out_ff <= date_out_in;
      hms_out_ff  <= hms_out_in;
   end

   assign rsp_bus.valid  = vld_ff[STAGES-1];
   assign rsp_bus.year   = date_out_ff.year;
   assign rsp_bus.month  = date_out_ff.month;
   assign rsp_bus.day    = date_out_ff.day;
   assign rsp_bus.hour   = hms_out_ff.hour;
   assign rsp_bus.minute = hms_out_ff.minute;
   assign rsp_bus.second = hms_out_ff.second;

endmodule

// ===== rtl/ut2cal_day_split.sv =====
// Stages 1-4: add zone offset, then split seconds into whole days and second of day.
module ut2cal_day_split (
   input  logic                      clock,
   input  logic                      en,
   input  ut2cal_pkg::stamp_type     stamp,
   input  ut2cal_pkg::zone_type      zone,
   output ut2cal_pkg::day_split_type split
);
   import ut2cal_pkg::*;

   logic [31:0]   t1_in, t1_ff;
   logic [50:0]   p2_in, p2_ff;
   logic [31:0]   t2_ff;
   logic [15:0]   q3_in, q3_ff;
   logic [31:0]   qd3_in, qd3_ff;
   logic [31:0]   t3_ff;
   logic [17:0]   r4;
   day_split_type s4_in, s4_ff;

   // stage 1: offset add, wraps mod 2^32
   assign t1_in = stamp + {{(32-ZONE_W){zone[ZONE_W-1]}}, zone};

   // stage 2: (t >> 7) * 2^35/675
   assign p2_in = 51'(t1_ff[31:7]) * 51'(RECIP_DAY);

   // stage 3: estimate is exact or one low
   assign q3_in  = p2_ff[50:35];
   assign qd3_in = 32'(33'(q3_in) * 33'(SECS_PER_DAY));

   // stage 4: one correction step
   always_comb begin
      r4 = 18'(t3_ff - qd3_ff);
      if (r4 >= {1'b0, SECS_PER_DAY}) begin
         s4_in.days = q3_ff + 16'd1;
         s4_in.sod  = 17'(r4 - {1'b0, SECS_PER_DAY});
      end else begin
         s4_in.days = q3_ff;
         s4_in.sod  = r4[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff  <= t1_in;
         p2_ff  <= p2_in;
         t2_ff  <= t1_ff;
         q3_ff  <= q3_in;
         qd3_ff <= qd3_in;
         t3_ff  <= t2_ff;
         s4_ff  <= s4_in;
      end
   end

   assign split = s4_ff;

endmodule

// ===== rtl/ut2cal_date.sv =====
// Stages 5-8: day count to year, month and day of month.
module ut2cal_date (
   input  logic                      clock,
   input  logic                      en,
   input  ut2cal_pkg::days_type      days,
   output ut2cal_pkg::date_type      date
);
   import ut2cal_pkg::*;

   logic [32:0] py5_in, py5_ff;
   days_type    d5_ff;
   logic [7:0]  e6;
   logic [7:0]  e6_prev;
   logic [7:0]  y6_in, y6_ff;
   logic [8:0]  doy6_in, doy6_ff;
   logic [11:1] ge7;
   month_type   month7_in, month7_ff;
   logic        leap7_in, leap7_ff;
   logic [8:0]  doy7_ff;
   logic [7:0]  y7_ff;
   logic [3:0]  midx8;
   logic [8:0]  mstart8;
   date_type    date8_in, date8_ff;

   // stage 5: estimate of floor(days / 365), never below the true year offset
   assign py5_in = 33'(days) * 33'(RECIP_YEAR);

   // stage 6: estimate is the year or one past it
   always_comb begin
      e6      = py5_ff[32:25];
      e6_prev = (e6 == 8'd0) ? 8'd0 : e6 - 8'd1;
      if (d5_ff < YEAR_START[e6]) begin
         y6_in   = e6_prev;
         doy6_in = 9'(d5_ff - YEAR_START[e6_prev]);
      end else begin
         y6_in   = e6;
         doy6_in = 9'(d5_ff - YEAR_START[e6]);
      end
   end

   // stage 7: month = 1 + number of month starts passed
   always_comb begin
      leap7_in = LEAP_YEARS[y6_ff];
      for (int k = 1; k < 12; k++) begin
         ge7[k] = doy6_ff >= (MONTH_START[k] + 9'((leap7_in && k >= 2) ? 1 : 0));
      end
      month7_in = 4'd1 + 4'($countones(ge7));
   end

   // stage 8: day of month and calendar year
   always_comb begin
      midx8          = month7_ff - 4'd1;
      mstart8        = MONTH_START[midx8] + {8'd0, leap7_ff && (midx8 >= 4'd2)};
      date8_in.day   = 5'(doy7_ff - mstart8 + 9'd1);
      date8_in.month = month7_ff;
      date8_in.year  = 12'(EPOCH_YEAR) + 12'(y7_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         py5_ff    <= py5_in;
         d5_ff     <= days;
         y6_ff     <= y6_in;
         doy6_ff   <= doy6_in;
         month7_ff <= month7_in;
         leap7_ff  <= leap7_in;
         doy7_ff   <= doy6_ff;
         y7_ff     <= y6_ff;
         date8_ff  <= date8_in;
      end
   end

   assign date = date8_ff;

endmodule

// ===== rtl/ut2cal_clock.sv =====
// Stages 5-8: second of day to hour, minute and second.
// Minute and second leave combinationally from the last register.
module ut2cal_clock (
   input  logic                   clock,
   input  logic                   en,
   input  ut2cal_pkg::sod_type    sod,
   output ut2cal_pkg::clock_type  hms
);
   import ut2cal_pkg::*;

   logic [33:0] ph5_in, ph5_ff;
   sod_type     sod5_ff;
   hour_type    hour6_in, hour6_ff;
   logic [16:0] hd6_in, hd6_ff;
   sod_type     sod6_ff;
   logic [11:0] rem7_in, rem7_ff;
   hour_type    hour7_ff;
   logic [24:0] pm8_in, pm8_ff;
   logic [11:0] rem8_ff;
   hour_type    hour8_ff;
   minute_type  minute8;
   logic [11:0] md8;

   // stage 5: sod * 2^28/3600, exact floor for sod below one day
   assign ph5_in = 34'(sod) * 34'(RECIP_HOUR);

   // stage 6: hour and its seconds
   assign hour6_in = ph5_ff[32:28];
   assign hd6_in   = 17'(hour6_in) * 17'(SECS_PER_HOUR);

   // stage 7: seconds within the hour
   assign rem7_in = 12'(sod6_ff - hd6_ff);

   // stage 8: rem * 2^18/60
   assign pm8_in = 25'(rem7_ff) * 25'(RECIP_MIN);

   // minute and second from the last register
   always_comb begin
      minute8    = pm8_ff[23:18];
      md8        = 12'(minute8) * 12'(SECS_PER_MIN);
      hms.hour   = hour8_ff;
      hms.minute = minute8;
      hms.second = 6'(rem8_ff - md8);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph5_ff   <= ph5_in;
         sod5_ff  <= sod;
         hour6_ff <= hour6_in;
         hd6_ff   <= hd6_in;
         sod6_ff  <= sod5_ff;
         rem7_ff  <= rem7_in;
         hour7_ff <= hour6_ff;
         pm8_ff   <= pm8_in;
         rem8_ff  <= rem7_ff;
         hour8_ff <= hour7_ff;
      end
   end

endmodule

// ===== rtl/ut2cal_checker.sv =====
`include "unix_time_to_calendar_unit_assert.svh"

// Port-level checks on the calendar unit.
module ut2cal_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ut2cal_pkg::month_type  rsp_month,
   input ut2cal_pkg::day_type    rsp_day,
   input ut2cal_pkg::hour_type   rsp_hour
);
   import ut2cal_pkg::*;

   logic fields_ok;

   // month, day and hour inside their calendar ranges
   assign fields_ok = rsp_month >= 4'd1 && rsp_month <= 4'd12 &&
                      rsp_day >= 5'd1 && rsp_day <= 5'd31 && rsp_hour <= 5'd23;

   // a waiting result stays until taken
   `UT2CAL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // input side only stalls behind a blocked result
   `UT2CAL_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // reset empties the pipeline
   `UT2CAL_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // calendar fields stay in range
   `UT2CAL_ASSERT_IMP(a_field_range, clock, reset, rsp_valid, fields_ok)

endmodule

bind unix_time_to_calendar_unit ut2cal_checker u_ut2cal_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_month (rsp_bus.month),
   .rsp_day   (rsp_bus.day),
   .rsp_hour  (rsp_bus.hour)
);

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ut2cal_pkg::*;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          LONG_HOLD      = 150;
   localparam int          DRAIN_CYCLES   = 12;
   localparam int          UNUSED_INDEX   = 1;
   localparam logic [31:0] DAY_SECS       = 32'd86400;

   localparam logic [CSR_ADDR_W-1:0] ZONE_ADDR   = CSR_ADDR_W'(4 * REG_ZONE_OFFSET);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4 * UNUSED_INDEX);

   // epoch start, one past zero and the points where the +8 h offset wraps
   localparam stamp_type RESET_ZONE_STAMPS [5] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd4294938495, 32'd4294938496
   };
   // leap days, year ends, 2000 (leap century) and 2100 (common century), zone 0
   localparam stamp_type UTC_EDGES [11] = '{
      32'd68169600, 32'd68255999, 32'd68256000, 32'd946684799, 32'd946684800,
      32'd951782400, 32'd951868799, 32'd978307199, 32'd4107542399,
      32'd4107542400, 32'd4133980799
   };
   // negative offset on small stamps wraps toward 2106
   localparam stamp_type WEST_WRAP_STAMPS [3] = '{32'd0, 32'd43199, 32'd43200};
   // positive offset on large stamps wraps toward 1970
   localparam stamp_type EAST_WRAP_STAMPS [2] = '{32'hFFFF_FFFF, 32'd4294916895};

   typedef struct packed {
      year_type   year;
      month_type  month;
      day_type    day;
      hour_type   hour;
      minute_type minute;
      second_type second;
   } cal_t;

   // Keeps the zone offset and the calendar dates still owed by the block.
   class calendar_tracker;
      zone_type zone;
      cal_t     expected_dates[$];

      function new();
         zone = zone_type'(ZONE_RESET);
      endfunction

      function bit leap_year(int unsigned yr);
         return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      endfunction

      function int unsigned month_days(int unsigned yr, int unsigned mo);
         case (mo)
            2: begin
               return leap_year(yr) ? 29 : 28;
            end
            4, 6, 9, 11: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      // strip whole years, then whole months, then split the rest
      function cal_t to_calendar(stamp_type ts, zone_type ofs);
         logic [31:0] t;
         logic [31:0] span;
         int unsigned yr;
         int unsigned mo;
         bit          done;
         cal_t        c;
         t    = ts + {{(32 - ZONE_W){ofs[ZONE_W-1]}}, ofs};
         yr   = EPOCH_YEAR;
         done = 1'b0;
         while (!done) begin
            span = (leap_year(yr) ? 32'd366 : 32'd365) * DAY_SECS;
            if (t < span) begin
               done = 1'b1;
            end else begin
               t  = t - span;
               yr = yr + 1;
            end
         end
         mo   = 1;
         done = 1'b0;
         while (!done) begin
            span = month_days(yr, mo) * DAY_SECS;
            if (t < span || mo >= 12) begin
               done = 1'b1;
            end else begin
               t  = t - span;
               mo = mo + 1;
            end
         end
         c.year   = year_type'(yr);
         c.month  = month_type'(mo);
         c.day    = day_type'(t / DAY_SECS + 1);
         t        = t % DAY_SECS;
         c.hour   = hour_type'(t / 3600);
         c.minute = minute_type'((t % 3600) / 60);
         c.second = second_type'(t % 60);
         return c;
      endfunction

      function void note_stamp(stamp_type ts);
         expected_dates.push_back(to_calendar(ts, zone));
      endfunction

      function string fmt(cal_t c);
         return $sformatf("%0d-%0d-%0d %0d:%0d:%0d",
                          c.year, c.month, c.day, c.hour, c.minute, c.second);
      endfunction

      // compares against the oldest owed date; returns 1 on a match
      function bit check_result(cal_t got, output string why);
         cal_t want;
         why = "";
         if (expected_dates.size() == 0) begin
            why = $sformatf("result %s with nothing pending", fmt(got));
            return 1'b0;
         end
         want = expected_dates.pop_front();
         if (got.year !== want.year)     why = {why, " year"};
         if (got.month !== want.month)   why = {why, " month"};
         if (got.day !== want.day)       why = {why, " day"};
         if (got.hour !== want.hour)     why = {why, " hour"};
         if (got.minute !== want.minute) why = {why, " minute"};
         if (got.second !== want.second) why = {why, " second"};
         if (why != "") begin
            why = $sformatf("bad%s: got %s, want %s", why, fmt(got), fmt(want));
         end
         return why == "";
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ut2cal_req_if req_if();
   ut2cal_rsp_if rsp_if();

   calendar_tracker sb = new();
   int              fail_count = 0;
   int              quiet_cycles = 0;
   bit              steady = 1'b0;
   bit              stall_burst = 1'b0;

   unix_time_to_calendar_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if.sink),
      .rsp_bus     (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   initial begin
      req_if.valid     = 1'b0;
      req_if.timestamp = '0;
      rsp_if.ready     = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: check accepted dates, then pick the next ready level
   initial begin : result_sink
      cal_t  got;
      string why;
      int    hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.year, rsp_if.month, rsp_if.day,
                    rsp_if.hour, rsp_if.minute, rsp_if.second};
            if (!sb.check_result(got, why)) report_mismatch(why);
         end
         if (stall_burst) begin
            hold        = LONG_HOLD;
            stall_burst = 1'b0;
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else begin
            rsp_if.ready <= 1'b1;
            hold = idle_len();
         end
      end
   end

   // watchdog: too long without any item moving
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_stamp(stamp_type ts);
      int gap;
      req_if.valid     <= 1'b1;
      req_if.timestamp <= ts;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_stamp(ts);
      gap = idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering, wait for every owed date, then let the pipeline settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write while idle, junk in the upper bits, then read the offset back
   task automatic csr_update(logic [CSR_ADDR_W-1:0] addr, int value);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] back;
      wait_drained();
      data             = $urandom;
      data[ZONE_W-1:0] = zone_type'(value);
      csr_write(addr, data);
      if (addr == ZONE_ADDR) sb.zone = data[ZONE_W-1:0];
      csr_read(ZONE_ADDR, back);
      if (back[ZONE_W-1:0] !== sb.zone) begin
         report_mismatch($sformatf("zone readback %h, want %h", back[ZONE_W-1:0], sb.zone));
      end
   endtask

   // random stamps: plain, near month and year starts in local time, near the wrap
   task automatic run_random(int count);
      longint      days;
      longint      utc;
      int unsigned yr;
      int unsigned mo;
      int          kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            send_stamp($urandom);
         end else if (kind < 85) begin
            yr   = $urandom_range(EPOCH_YEAR, 2106);
            mo   = $urandom_range(1, 12);
            days = 0;
            for (int unsigned y = EPOCH_YEAR; y < yr; y++) days += sb.leap_year(y) ? 366 : 365;
            for (int unsigned m = 1; m < mo; m++) days += sb.month_days(yr, m);
            utc = days * 86400 - longint'($signed(sb.zone))
                  + longint'($urandom_range(0, 172800)) - 86400;
            send_stamp(stamp_type'(utc));
         end else if (kind < 93) begin
            send_stamp(stamp_type'($urandom_range(0, 200000)));
         end else begin
            send_stamp(32'hFFFF_FFFF - stamp_type'($urandom_range(0, 200000)));
         end
      end
   endtask

   initial begin : stimulus
      int phase_zone [8];
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset offset, leap and century edges, offset wrap both ways
      foreach (RESET_ZONE_STAMPS[i]) send_stamp(RESET_ZONE_STAMPS[i]);
      csr_update(ZONE_ADDR, 0);
      foreach (UTC_EDGES[i]) send_stamp(UTC_EDGES[i]);
      csr_update(ZONE_ADDR, -43200);
      foreach (WEST_WRAP_STAMPS[i]) send_stamp(WEST_WRAP_STAMPS[i]);
      csr_update(ZONE_ADDR, 50400);
      foreach (EAST_WRAP_STAMPS[i]) send_stamp(EAST_WRAP_STAMPS[i]);
      // a write past the only register must leave the offset alone
      csr_update(UNUSED_ADDR, $urandom);
      send_stamp(32'd0);

      // random phases over extreme, in-range and raw 17-bit offsets
      phase_zone = '{65535, -65536, 0, -43200, 50400,
                     $urandom_range(0, 93600) - 43200,
                     $urandom_range(0, 93600) - 43200, $urandom};
      foreach (phase_zone[p]) begin
         csr_update(ZONE_ADDR, phase_zone[p]);
         if (p == 1) stall_burst = 1'b1;
         steady = (p == 3);
         run_random(135);
         steady = 1'b0;
      end

      wait_drained();
      if (fail_count == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
